@@ rtl/sphere_vertex_generator_core_macros.svh @@
// Assertion macros for the sphere vertex generator core.
`ifndef SPHERE_VERTEX_GENERATOR_CORE_MACROS_SVH
`define SPHERE_VERTEX_GENERATOR_CORE_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define SVG_ASSERT_IMPLY(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define SVG_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define SVG_ASSERT_IMPLY(name, ante, cons, msg)
`define SVG_ASSERT_NEXT(name, ante, cons, msg)
`endif
`endif

@@ rtl/svg_pkg.sv @@
// Shared constants and the arctangent table of the sphere vertex generator.
package svg_pkg;

   // Angle and rotation unit sizes.
   localparam int ANGLE_BITS    = 16;
   localparam int TURN_BITS     = 24;
   localparam int CORDIC_STEPS  = 20;
   localparam int STEP_BITS     = 5;
   localparam int CORDIC_W      = 32;
   localparam int Z_W           = TURN_BITS + 1;
   localparam int MAX_DIVISIONS = 256;
   localparam int COUNT_W       = 9;

   // Gain-compensated unit vector in Q1.30.
   localparam logic signed [CORDIC_W-1:0] CORDIC_START = 32'sd652032874;

   // Quarter and half turn in the widened angle format.
   localparam logic signed [Z_W-1:0] Z_QUARTER = Z_W'(1 << (TURN_BITS - 2));
   localparam logic signed [Z_W-1:0] Z_HALF    = Z_W'(1 << (TURN_BITS - 1));

   // Three quarters of a turn; turns the stack angle into latitude.
   localparam logic [ANGLE_BITS-1:0] BETA_OFFSET = ANGLE_BITS'(3 << (ANGLE_BITS - 2));

   // Configuration port.
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;
   localparam logic [CSR_INDEX_W-1:0] REG_RADIUS = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_STACKS = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_SLICES = 2'd2;

   // Arctangent of 2^-k as a fraction of a turn, 24 fractional bits.
   function automatic logic signed [Z_W-1:0] atan_turn(input logic [STEP_BITS-1:0] k);
      logic signed [Z_W-1:0] v;
      case (k)
         5'd0:    v = 25'sd2097152;
         5'd1:    v = 25'sd1238021;
         5'd2:    v = 25'sd654136;
         5'd3:    v = 25'sd332050;
         5'd4:    v = 25'sd166669;
         5'd5:    v = 25'sd83416;
         5'd6:    v = 25'sd41718;
         5'd7:    v = 25'sd20860;
         5'd8:    v = 25'sd10430;
         5'd9:    v = 25'sd5215;
         5'd10:   v = 25'sd2608;
         5'd11:   v = 25'sd1304;
         5'd12:   v = 25'sd652;
         5'd13:   v = 25'sd326;
         5'd14:   v = 25'sd163;
         5'd15:   v = 25'sd81;
         5'd16:   v = 25'sd41;
         5'd17:   v = 25'sd20;
         5'd18:   v = 25'sd10;
         5'd19:   v = 25'sd5;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

@@ rtl/svg_cordic.sv @@
// Iterative rotation-mode CORDIC giving cosine and sine of one angle.
module svg_cordic (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  cor_start,
   input  logic [svg_pkg::ANGLE_BITS-1:0]        cor_angle,
   output logic                                  cor_done,
   output logic signed [svg_pkg::CORDIC_W-1:0]   cor_cos,
   output logic signed [svg_pkg::CORDIC_W-1:0]   cor_sin
);
   import svg_pkg::*;

   logic                         busy_ff, busy_in;
   logic                         done_ff, done_in;
   logic                         neg_ff, neg_in;
   logic [STEP_BITS-1:0]         k_ff, k_in;
   logic signed [CORDIC_W-1:0]   x_ff, x_in;
   logic signed [CORDIC_W-1:0]   y_ff, y_in;
   logic signed [Z_W-1:0]        z_ff, z_in;
   logic signed [CORDIC_W-1:0]   cos_ff, cos_in;
   logic signed [CORDIC_W-1:0]   sin_ff, sin_in;

   logic [TURN_BITS-1:0]         turn;
   logic signed [Z_W-1:0]        z_wrap;
   logic signed [Z_W-1:0]        z_fold;
   logic                         neg_fold;
   logic signed [CORDIC_W-1:0]   xs, ys;
   logic signed [CORDIC_W-1:0]   x_step, y_step;
   logic signed [Z_W-1:0]        z_step;

   // Widen the angle and fold the left half plane onto the right one.
   always_comb begin
      turn     = {cor_angle, {(TURN_BITS - ANGLE_BITS){1'b0}}};
      z_wrap   = $signed({turn[TURN_BITS-1], turn});
      z_fold   = z_wrap;
      neg_fold = 1'b0;
      if (z_wrap > Z_QUARTER) begin
         z_fold   = z_wrap - Z_HALF;
         neg_fold = 1'b1;
      end else if (z_wrap < -Z_QUARTER) begin
         z_fold   = z_wrap + Z_HALF;
         neg_fold = 1'b1;
      end
   end

   // One micro-rotation, direction set by the sign of the residual angle.
   always_comb begin
      xs = x_ff >>> k_ff;
      ys = y_ff >>> k_ff;
      if (!z_ff[Z_W-1]) begin
         x_step = x_ff - ys;
         y_step = y_ff + xs;
         z_step = z_ff - atan_turn(k_ff);
      end else begin
         x_step = x_ff + ys;
         y_step = y_ff - xs;
         z_step = z_ff + atan_turn(k_ff);
      end
   end

   // Iteration sequencer.
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      neg_in  = neg_ff;
      k_in    = k_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      cos_in  = cos_ff;
      sin_in  = sin_ff;
      if (cor_start) begin
         busy_in = 1'b1;
         k_in    = '0;
         x_in    = CORDIC_START;
         y_in    = '0;
         z_in    = z_fold;
         neg_in  = neg_fold;
      end else if (busy_ff) begin
         x_in = x_step;
         y_in = y_step;
         z_in = z_step;
         if (k_ff == STEP_BITS'(CORDIC_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            cos_in  = neg_ff ? -x_step : x_step;
            sin_in  = neg_ff ? -y_step : y_step;
         end else begin
            k_in = k_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff <= neg_in;
      k_ff   <= k_in;
      x_ff   <= x_in;
      y_ff   <= y_in;
      z_ff   <= z_in;
      cos_ff <= cos_in;
      sin_ff <= sin_in;
   end

   assign cor_done = done_ff;
   assign cor_cos  = cos_ff;
   assign cor_sin  = sin_ff;

endmodule

@@ rtl/sphere_vertex_generator_core.sv @@
// Top level of the UV sphere vertex generator.
//
//   channel  direction  transfer when           carries
//   req      in         req_tvalid & tready     restart flag
//   rsp      out        rsp_tvalid & tready     x, y, z, vertex number, last vertex
//   csr      in         csr_we                  radius, stack count, slice count
//
// A ring vertex takes two CORDIC passes on the shared rotation unit, plus seven operations
// on the shared multiplier. After a count register is written, the next ring vertex adds
// two 17-step divisions for the angle steps. req_tready is high only while no item is in work.
// A finished vertex waits in the result register while rsp_tready is low; reset is
// synchronous and returns the sequence to the south pole with the default registers.
`include "sphere_vertex_generator_core_macros.svh"
module sphere_vertex_generator_core (
   input  logic                               clock,
   input  logic                               reset,
   // Configuration write port.
   input  logic                               csr_we,
   input  logic [svg_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [svg_pkg::CSR_DATA_W-1:0]     csr_wdata,
   // Advance requests.
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [7:0]                         req_tdata,  // [0] restart, [7:1] zero
   // Vertices.
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [16:0] x_coord, [33:17] y_coord, [50:34] z_coord, [66:51] vertex_number, [71:67] zero
   output logic [71:0]                        rsp_tdata,
   output logic                               rsp_tlast
);
   import svg_pkg::*;

   typedef enum logic [5:0] {
      S_IDLE = 6'b000001,
      S_DIV  = 6'b000010,
      S_MUL  = 6'b000100,
      S_MWB  = 6'b001000,
      S_CORD = 6'b010000,
      S_OUT  = 6'b100000
   } state_type;

   typedef enum logic [2:0] {
      OP_BETA,
      OP_ALPHA,
      OP_FX,
      OP_FZ,
      OP_Y,
      OP_X,
      OP_Z
   } op_type;

   localparam logic [1:0] PH_SOUTH = 2'd0;
   localparam logic [1:0] PH_RING  = 2'd1;
   localparam logic [1:0] PH_NORTH = 2'd2;

   localparam int COORD_W = 17;
   localparam logic signed [63:0] ROUND_HALF = 64'sd536870912;
   localparam logic signed [COORD_W-1:0] COORD_MAX = 17'sh0FFFF;
   localparam logic signed [COORD_W-1:0] COORD_MIN = 17'sh10000;
   localparam logic [STEP_BITS-1:0] DIV_LAST = STEP_BITS'(ANGLE_BITS);

   // Count register as used: zero acts as one, large values clip.
   function automatic logic [COUNT_W-1:0] eff_count(input logic [COUNT_W-1:0] c);
      logic [COUNT_W-1:0] v;
      v = c;
      if (c == '0) v = COUNT_W'(1);
      else if (c > COUNT_W'(MAX_DIVISIONS)) v = COUNT_W'(MAX_DIVISIONS);
      return v;
   endfunction

   // Round a Q2.60-scaled product back by 30 bits, floor of value plus one half.
   function automatic logic signed [33:0] round_q30(input logic signed [63:0] p);
      logic signed [63:0] t;
      t = p + ROUND_HALF;
      return $signed(t[63:30]);
   endfunction

   // Clip a rounded coordinate to the signed Q8.8 output range.
   function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [33:0] v);
      logic signed [COORD_W-1:0] r;
      if (v > 34'sd65535) r = COORD_MAX;
      else if (v < -34'sd65536) r = COORD_MIN;
      else r = $signed(v[COORD_W-1:0]);
      return r;
   endfunction

   // Registers.
   state_type                  state_ff, state_in;
   op_type                     mop_ff, mop_in;
   logic [15:0]                radius_ff, radius_in;
   logic [COUNT_W-1:0]         stack_count_ff, stack_count_in;
   logic [COUNT_W-1:0]         slice_count_ff, slice_count_in;
   logic [1:0]                 phase_ff, phase_in;
   logic [COUNT_W-1:0]         stack_index_ff, stack_index_in;
   logic [COUNT_W-1:0]         slice_index_ff, slice_index_in;
   logic [15:0]                vcount_ff, vcount_in;
   logic                       steps_ok_ff, steps_ok_in;
   logic [ANGLE_BITS-1:0]      slice_step_ff, slice_step_in;
   logic [ANGLE_BITS-1:0]      stack_step_ff, stack_step_in;
   logic                       div_sel_ff, div_sel_in;
   logic [STEP_BITS-1:0]       div_cnt_ff, div_cnt_in;
   logic [COUNT_W-1:0]         rem_ff, rem_in;
   logic [ANGLE_BITS:0]        quo_ff, quo_in;
   logic [COUNT_W-1:0]         st_cur_ff, st_cur_in;
   logic [COUNT_W-1:0]         sl_cur_ff, sl_cur_in;
   logic signed [63:0]         prod_ff, prod_in;
   logic signed [CORDIC_W-1:0] cb_ff, cb_in, sb_ff, sb_in;
   logic signed [CORDIC_W-1:0] ca_ff, ca_in, sa_ff, sa_in;
   logic signed [CORDIC_W-1:0] fx_ff, fx_in, fz_ff, fz_in;
   logic signed [COORD_W-1:0]  res_x_ff, res_x_in;
   logic signed [COORD_W-1:0]  res_y_ff, res_y_in;
   logic signed [COORD_W-1:0]  res_z_ff, res_z_in;
   logic [15:0]                res_num_ff, res_num_in;
   logic                       res_last_ff, res_last_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [71:0]                rsp_data_ff, rsp_data_in;
   logic                       rsp_last_ff, rsp_last_in;

   // Combinational signals.
   logic [COUNT_W-1:0]         stacks, slices;
   logic                       restart;
   logic [1:0]                 ph0, ph1, ph2;
   logic [COUNT_W-1:0]         st0, st1, st2, sl0, sl1, sl2, sl_inc;
   logic [15:0]                cnt0;
   logic                       ring0;
   logic [COUNT_W-1:0]         div_by;
   logic [COUNT_W:0]           div_try;
   logic                       div_ge;
   logic [ANGLE_BITS:0]        quo_next;
   logic signed [CORDIC_W-1:0] op_a, op_b;
   logic                       cor_start;
   logic [ANGLE_BITS-1:0]      cor_angle;
   logic                       cor_done;
   logic signed [CORDIC_W-1:0] cor_cos, cor_sin;
   logic signed [33:0]         prod_round;

   assign stacks  = eff_count(stack_count_ff);
   assign slices  = eff_count(slice_count_ff);
   assign restart = req_tdata[0];

   // Position of the vertex this transfer emits, and the position after it.
   always_comb begin
      ph0   = restart ? PH_SOUTH : phase_ff;
      st0   = restart ? COUNT_W'(1) : stack_index_ff;
      sl0   = restart ? '0 : slice_index_ff;
      cnt0  = restart ? '0 : vcount_ff;
      ring0 = (ph0 == PH_RING);
      if (ring0 && (sl0 >= slices)) begin
         sl1 = '0;
         st1 = st0 + 1'b1;
      end else begin
         sl1 = sl0;
         st1 = st0;
      end
      ph1    = (ring0 && (st1 >= stacks)) ? PH_NORTH : ph0;
      sl_inc = sl1 + 1'b1;
      if (sl_inc >= slices) begin
         sl2 = '0;
         st2 = st1 + 1'b1;
      end else begin
         sl2 = sl_inc;
         st2 = st1;
      end
      ph2 = (st2 >= stacks) ? PH_NORTH : PH_RING;
   end

   // Restoring divider step: 2^16 divided by a count, one quotient bit per cycle.
   always_comb begin
      div_by   = div_sel_ff ? stacks : slices;
      div_try  = {rem_ff, (div_cnt_ff == '0)};
      div_ge   = (div_try >= {1'b0, div_by});
      quo_next = {quo_ff[ANGLE_BITS-1:0], div_ge};
   end

   // Operand selection for the shared multiplier.
   always_comb begin
      case (mop_ff)
         OP_BETA: begin
            op_a = $signed({16'b0, stack_step_ff});
            op_b = $signed({23'b0, st_cur_ff});
         end
         OP_ALPHA: begin
            op_a = $signed({16'b0, slice_step_ff});
            op_b = $signed({23'b0, sl_cur_ff});
         end
         OP_FX: begin
            op_a = cb_ff;
            op_b = sa_ff;
         end
         OP_FZ: begin
            op_a = cb_ff;
            op_b = ca_ff;
         end
         OP_Y: begin
            op_a = $signed({16'b0, radius_ff});
            op_b = sb_ff;
         end
         OP_X: begin
            op_a = $signed({16'b0, radius_ff});
            op_b = fx_ff;
         end
         OP_Z: begin
            op_a = $signed({16'b0, radius_ff});
            op_b = fz_ff;
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
   end

   assign prod_round = round_q30(prod_ff);
   assign cor_angle  = (mop_ff == OP_BETA) ? prod_ff[ANGLE_BITS-1:0] + BETA_OFFSET
                                           : prod_ff[ANGLE_BITS-1:0];

   // Shared rotation unit for both angles.
   svg_cordic u_cordic (
      .clock     (clock),
      .reset     (reset),
      .cor_start (cor_start),
      .cor_angle (cor_angle),
      .cor_done  (cor_done),
      .cor_cos   (cor_cos),
      .cor_sin   (cor_sin)
   );

   // Sequencer and next-state logic.
   always_comb begin
      state_in       = state_ff;
      mop_in         = mop_ff;
      radius_in      = radius_ff;
      stack_count_in = stack_count_ff;
      slice_count_in = slice_count_ff;
      phase_in       = phase_ff;
      stack_index_in = stack_index_ff;
      slice_index_in = slice_index_ff;
      vcount_in      = vcount_ff;
      steps_ok_in    = steps_ok_ff;
      slice_step_in  = slice_step_ff;
      stack_step_in  = stack_step_ff;
      div_sel_in     = div_sel_ff;
      div_cnt_in     = div_cnt_ff;
      rem_in         = rem_ff;
      quo_in         = quo_ff;
      st_cur_in      = st_cur_ff;
      sl_cur_in      = sl_cur_ff;
      prod_in        = prod_ff;
      cb_in          = cb_ff;
      sb_in          = sb_ff;
      ca_in          = ca_ff;
      sa_in          = sa_ff;
      fx_in          = fx_ff;
      fz_in          = fz_ff;
      res_x_in       = res_x_ff;
      res_y_in       = res_y_ff;
      res_z_in       = res_z_ff;
      res_num_in     = res_num_ff;
      res_last_in    = res_last_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_data_in    = rsp_data_ff;
      rsp_last_in    = rsp_last_ff;
      cor_start      = 1'b0;

      // Register writes; a new count invalidates the angle steps.
      if (csr_we) begin
         case (csr_index)
            REG_RADIUS: radius_in = csr_wdata;
            REG_STACKS: begin
               stack_count_in = csr_wdata[COUNT_W-1:0];
               steps_ok_in    = 1'b0;
            end
            REG_SLICES: begin
               slice_count_in = csr_wdata[COUNT_W-1:0];
               steps_ok_in    = 1'b0;
            end
            default: ;
         endcase
      end

      // The consumer takes the waiting vertex.
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               res_num_in = cnt0;
               if (ph1 == PH_RING) begin
                  st_cur_in      = st1;
                  sl_cur_in      = sl1;
                  vcount_in      = cnt0 + 1'b1;
                  stack_index_in = st2;
                  slice_index_in = sl2;
                  phase_in       = ph2;
                  res_last_in    = 1'b0;
                  mop_in         = OP_BETA;
                  div_sel_in     = 1'b0;
                  div_cnt_in     = '0;
                  rem_in         = '0;
                  state_in       = steps_ok_ff ? S_MUL : S_DIV;
               end else if (ph1 == PH_NORTH) begin
                  res_x_in       = '0;
                  res_y_in       = $signed({1'b0, radius_ff});
                  res_z_in       = '0;
                  res_last_in    = 1'b1;
                  phase_in       = PH_SOUTH;
                  stack_index_in = COUNT_W'(1);
                  slice_index_in = '0;
                  vcount_in      = '0;
                  state_in       = S_OUT;
               end else begin
                  res_x_in       = '0;
                  res_y_in       = -$signed({1'b0, radius_ff});
                  res_z_in       = '0;
                  res_last_in    = 1'b0;
                  vcount_in      = cnt0 + 1'b1;
                  stack_index_in = COUNT_W'(1);
                  slice_index_in = '0;
                  phase_in       = (stacks >= COUNT_W'(2)) ? PH_RING : PH_NORTH;
                  state_in       = S_OUT;
               end
            end
         end

         // Slice step first, then stack step as half of the stack quotient.
         S_DIV: begin
            rem_in = div_ge ? COUNT_W'(div_try - {1'b0, div_by}) : div_try[COUNT_W-1:0];
            quo_in = quo_next;
            if (div_cnt_ff == DIV_LAST) begin
               div_cnt_in = '0;
               rem_in     = '0;
               if (!div_sel_ff) begin
                  slice_step_in = quo_next[ANGLE_BITS-1:0];
                  div_sel_in    = 1'b1;
               end else begin
                  stack_step_in = quo_next[ANGLE_BITS:1];
                  steps_ok_in   = 1'b1;
                  state_in      = S_MUL;
               end
            end else begin
               div_cnt_in = div_cnt_ff + 1'b1;
            end
         end

         S_MUL: begin
            prod_in  = op_a * op_b;
            state_in = S_MWB;
         end

         // Use the registered product.
         S_MWB: begin
            case (mop_ff)
               OP_BETA, OP_ALPHA: begin
                  cor_start = 1'b1;
                  state_in  = S_CORD;
               end
               OP_FX: begin
                  fx_in    = prod_round[CORDIC_W-1:0];
                  mop_in   = OP_FZ;
                  state_in = S_MUL;
               end
               OP_FZ: begin
                  fz_in    = prod_round[CORDIC_W-1:0];
                  mop_in   = OP_Y;
                  state_in = S_MUL;
               end
               OP_Y: begin
                  res_y_in = sat_coord(prod_round);
                  mop_in   = OP_X;
                  state_in = S_MUL;
               end
               OP_X: begin
                  res_x_in = sat_coord(prod_round);
                  mop_in   = OP_Z;
                  state_in = S_MUL;
               end
               OP_Z: begin
                  res_z_in = sat_coord(prod_round);
                  state_in = S_OUT;
               end
               default: state_in = S_IDLE;
            endcase
         end

         S_CORD: begin
            if (cor_done) begin
               if (mop_ff == OP_BETA) begin
                  cb_in  = cor_cos;
                  sb_in  = cor_sin;
                  mop_in = OP_ALPHA;
               end else begin
                  ca_in  = cor_cos;
                  sa_in  = cor_sin;
                  mop_in = OP_FX;
               end
               state_in = S_MUL;
            end
         end

         // Hand the vertex to the result register once it is free.
         S_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {5'b0, res_num_ff, res_z_ff, res_y_ff, res_x_ff};
               rsp_last_in  = res_last_ff;
               state_in     = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         mop_ff         <= OP_BETA;
         radius_ff      <= 16'd256;
         stack_count_ff <= COUNT_W'(8);
         slice_count_ff <= COUNT_W'(8);
         phase_ff       <= PH_SOUTH;
         stack_index_ff <= COUNT_W'(1);
         slice_index_ff <= '0;
         vcount_ff      <= '0;
         steps_ok_ff    <= 1'b0;
         div_sel_ff     <= 1'b0;
         div_cnt_ff     <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         mop_ff         <= mop_in;
         radius_ff      <= radius_in;
         stack_count_ff <= stack_count_in;
         slice_count_ff <= slice_count_in;
         phase_ff       <= phase_in;
         stack_index_ff <= stack_index_in;
         slice_index_ff <= slice_index_in;
         vcount_ff      <= vcount_in;
         steps_ok_ff    <= steps_ok_in;
         div_sel_ff     <= div_sel_in;
         div_cnt_ff     <= div_cnt_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      slice_step_ff <= slice_step_in;
      stack_step_ff <= stack_step_in;
      rem_ff        <= rem_in;
      quo_ff        <= quo_in;
      st_cur_ff     <= st_cur_in;
      sl_cur_ff     <= sl_cur_in;
      prod_ff       <= prod_in;
      cb_ff         <= cb_in;
      sb_ff         <= sb_in;
      ca_ff         <= ca_in;
      sa_ff         <= sa_in;
      fx_ff         <= fx_in;
      fz_ff         <= fz_in;
      res_x_ff      <= res_x_in;
      res_y_ff      <= res_y_in;
      res_z_ff      <= res_z_in;
      res_num_ff    <= res_num_in;
      res_last_ff   <= res_last_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   // Checks on the sequencer and the pole output.
   `SVG_ASSERT_IMPLY(a_pole_on_axis, rsp_tvalid && rsp_tlast, rsp_tdata[16:0] == 17'd0 && rsp_tdata[50:34] == 17'd0, "north pole vertex is off the axis")
   `SVG_ASSERT_IMPLY(a_cordic_done_in_wait, cor_done, state_ff == S_CORD, "rotation result arrived outside its wait state")
   `SVG_ASSERT_IMPLY(a_steps_before_mul, state_ff == S_MUL, steps_ok_ff, "multiply issued with stale angle steps")
   `SVG_ASSERT_NEXT(a_accept_leaves_idle, req_tvalid && req_tready, state_ff != S_IDLE, "accepted transfer did not start work")

endmodule
